// ----- rtl/core/uri_esc_pkg.sv -----
package uri_esc_pkg;

  localparam int CountWidthDefault = 16;
  localparam int OutCountWidth     = 16;

  // escape_mode codes
  localparam logic [2:0] MODE_URI       = 3'd0;
  localparam logic [2:0] MODE_ARGS      = 3'd1;
  localparam logic [2:0] MODE_HTML      = 3'd2;
  localparam logic [2:0] MODE_REFRESH   = 3'd3;
  localparam logic [2:0] MODE_MEMCACHED = 3'd4;
  localparam logic [2:0] MODE_MAIL_AUTH = 3'd5;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  // 'A' minus ten
  localparam logic [7:0] CHAR_ALPHA   = 8'h37;

  // bit n of a map is set when byte value n gets escaped
  localparam logic [255:0] MAP_URI = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'ha8000000, 32'h78000000, 32'hfc00886d, 32'hffffffff};
  localparam logic [255:0] MAP_ARGS = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h80000829, 32'hffffffff};
  localparam logic [255:0] MAP_HTML = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h000000ad, 32'hffffffff};
  localparam logic [255:0] MAP_REFRESH = {
    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
    32'h80000000, 32'h00000000, 32'h00000085, 32'hffffffff};
  localparam logic [255:0] MAP_MEMCACHED = {
    32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000,
    32'h00000000, 32'h00000000, 32'h00000021, 32'hffffffff};

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_HI,
    PH_LO
  } phase_t;

  typedef struct packed {
    logic [7:0]               data;
    logic                     esc;
    logic                     last;
    logic [OutCountWidth-1:0] count;
  } item_t;

  function automatic logic needs_escape(input logic [2:0] mode, input logic [7:0] b);
    logic [255:0] map;
    case (mode)
      MODE_URI:     map = MAP_URI;
      MODE_ARGS:    map = MAP_ARGS;
      MODE_HTML:    map = MAP_HTML;
      MODE_REFRESH: map = MAP_REFRESH;
      default:      map = MAP_MEMCACHED;
    endcase
    return map[b];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    logic [7:0] n8;
    n8 = {4'h0, n};
    return (n < 4'd10) ? (CHAR_ZERO + n8) : (CHAR_ALPHA + n8);
  endfunction

endpackage

// ----- rtl/core/uri_esc_expand.sv -----
module uri_esc_expand (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  ld_valid,
  output logic                                  ld_ready,
  input  uri_esc_pkg::item_t                    ld_item,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_byte,
  output logic                                  out_run_last,
  output logic                                  out_string_last,
  output logic [uri_esc_pkg::OutCountWidth-1:0] out_escaped_count
);
  import uri_esc_pkg::*;

  logic                     valid_r, valid_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [7:0]               data_r;
  logic                     esc_r;
  logic                     last_r;
  logic [OutCountWidth-1:0] count_r;
  logic [7:0]               byte_r, byte_nxt;
  logic                     run_last_r, run_last_nxt;
  logic                     str_last_r, str_last_nxt;
  logic                     load;

  // free when empty or the final byte of this run is being taken
  assign ld_ready = !valid_r || (out_ready && run_last_r);
  assign load     = ld_valid && ld_ready;

  always_comb begin
    valid_nxt    = valid_r;
    phase_nxt    = phase_r;
    byte_nxt     = byte_r;
    run_last_nxt = run_last_r;
    str_last_nxt = str_last_r;
    if (load) begin
      valid_nxt    = 1'b1;
      phase_nxt    = PH_HEAD;
      byte_nxt     = ld_item.esc ? CHAR_PERCENT : ld_item.data;
      run_last_nxt = !ld_item.esc;
      str_last_nxt = !ld_item.esc && ld_item.last;
    end else if (valid_r && out_ready) begin
      if (run_last_r) begin
        valid_nxt = 1'b0;
      end else begin
        case (phase_r)
          PH_HEAD: begin
            phase_nxt    = PH_HI;
            byte_nxt     = hex_char(data_r[7:4]);
          end
          PH_HI: begin
            phase_nxt    = PH_LO;
            byte_nxt     = hex_char(data_r[3:0]);
            run_last_nxt = 1'b1;
            str_last_nxt = last_r;
          end
          default: begin
            phase_nxt = PH_HEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= PH_HEAD;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    run_last_r <= run_last_nxt;
    str_last_r <= str_last_nxt;
    if (load) begin
      data_r  <= ld_item.data;
      esc_r   <= ld_item.esc;
      last_r  <= ld_item.last;
      count_r <= ld_item.count;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_run_last      = run_last_r;
  assign out_string_last   = str_last_r;
  assign out_escaped_count = count_r;

  a_str_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && str_last_r |-> run_last_r)
    else $error("string_last without run_last");

  a_esc_run_ends_on_lo: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && esc_r && run_last_r |-> phase_r == PH_LO)
    else $error("escaped run ended early");

  a_percent_first: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && esc_r && phase_r == PH_HEAD |-> byte_r == CHAR_PERCENT)
    else $error("escape run does not open with percent");

  a_count_held_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_ready && !run_last_r |=> valid_r && $stable(count_r))
    else $error("count changed inside a run");

endmodule

// ----- rtl/core/uri_percent_escape.sv -----
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_byte, in_is_last
// out     | output    | out_valid / out_ready | out_byte, out_run_last, out_string_last,
//         |           |                       | out_escaped_count
// cfg     | input     | cfg_valid / cfg_ready | cfg_escape_mode
//
// a plain byte gives one byte on the output channel, an escaped byte three ('%', two hex
// digits); the byte-wide result register holds one of these bytes at a time
// an input transaction reaches the output through the input register, then the output register
// an input register and the output register let a new byte enter while a result waits
// synchronous active-low reset clears valid flags, mode (uri) and the escape tally
// cfg_ready is always high; the user must write the mode only while the block is idle (not enforced)
module uri_percent_escape #(
  parameter int COUNT_WIDTH = uri_esc_pkg::CountWidthDefault
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_byte,
  input  logic                                  in_is_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [7:0]                            out_byte,
  output logic                                  out_run_last,
  output logic                                  out_string_last,
  output logic [uri_esc_pkg::OutCountWidth-1:0] out_escaped_count,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [2:0]                            cfg_escape_mode
);
  import uri_esc_pkg::*;

  logic [2:0]               escape_mode_r;
  logic                     a_valid_r;
  logic [7:0]               a_byte_r;
  logic                     a_last_r;
  logic [COUNT_WIDTH-1:0]   tally_r, tally_nxt, tally_inc;
  logic [COUNT_WIDTH+OutCountWidth-1:0] tally_ext;
  logic                     a_esc;
  logic                     a_move;
  logic                     b_ready;
  item_t                    a_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      escape_mode_r <= MODE_URI;
    end else if (cfg_valid) begin
      escape_mode_r <= cfg_escape_mode;
    end
  end

  assign a_esc     = needs_escape(escape_mode_r, a_byte_r);
  assign tally_inc = (a_esc && (tally_r != {COUNT_WIDTH{1'b1}})) ?
                     tally_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1} : tally_r;
  assign tally_ext = {{OutCountWidth{1'b0}}, tally_inc};
  assign tally_nxt = a_last_r ? '0 : tally_inc;

  assign a_item.data  = a_byte_r;
  assign a_item.esc   = a_esc;
  assign a_item.last  = a_last_r;
  assign a_item.count = tally_ext[OutCountWidth-1:0];

  assign a_move   = a_valid_r && b_ready;
  assign in_ready = !a_valid_r || b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      tally_r   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid_r <= 1'b1;
      end else if (a_move) begin
        a_valid_r <= 1'b0;
      end
      if (a_move) begin
        tally_r <= tally_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_byte_r <= in_byte;
      a_last_r <= in_is_last;
    end
  end

  uri_esc_expand u_expand (
    .clk               (clk),
    .rst_n             (rst_n),
    .ld_valid          (a_valid_r),
    .ld_ready          (b_ready),
    .ld_item           (a_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_run_last      (out_run_last),
    .out_string_last   (out_string_last),
    .out_escaped_count (out_escaped_count)
  );

  a_tally_clears: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && a_last_r |=> tally_r == '0)
    else $error("tally not cleared at end of string");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_byte_r))
    else $error("stalled input item lost");

  a_tally_steps_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    a_move && !a_last_r |=> tally_r == $past(tally_r) || tally_r == $past(tally_r) + 1'b1)
    else $error("tally jumped");

endmodule
